[hdl/mfep_pkg.sv]
// Package: phase, kind and error codes, parser state and result types for the MIDI file parser.
`default_nettype none

package mfep_pkg;

    typedef enum logic [3:0] {
        PH_MAGIC     = 4'd0,
        PH_LENGTH    = 4'd1,
        PH_FORMAT    = 4'd2,
        PH_TRACKS    = 4'd3,
        PH_DIVISION  = 4'd4,
        PH_HALT      = 4'd5,
        PH_DELTA     = 4'd6,
        PH_STATUS    = 4'd7,
        PH_META      = 4'd8,
        PH_EOT_LEN   = 4'd9,
        PH_TEMPO_LEN = 4'd10,
        PH_TEMPO     = 4'd11,
        PH_NOTE      = 4'd12,
        PH_VELOCITY  = 4'd13
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HDR_OK  = 3'd0,
        KIND_HDR_ERR = 3'd1,
        KIND_OFF     = 3'd2,
        KIND_ON      = 3'd3,
        KIND_EOT     = 3'd4,
        KIND_TEMPO   = 3'd5,
        KIND_UNKNOWN = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_MAGIC  = 3'd1,
        ERR_LENGTH = 3'd2,
        ERR_FORMAT = 3'd3,
        ERR_TRACKS = 3'd4
    } hdr_err_t;

    localparam logic [7:0]  STATUS_MASK    = 8'hF0;
    localparam logic [7:0]  STATUS_OFF     = 8'h80;
    localparam logic [7:0]  STATUS_ON      = 8'h90;
    localparam logic [7:0]  STATUS_META    = 8'hFF;
    localparam logic [7:0]  META_EOT       = 8'h2F;
    localparam logic [7:0]  META_TEMPO     = 8'h51;
    localparam logic [7:0]  VLQ_CONT       = 8'h80;
    localparam logic [31:0] HEADER_LENGTH  = 32'd6;
    localparam logic [15:0] HEADER_FORMAT  = 16'd0;
    localparam logic [15:0] HEADER_TRACKS  = 16'd1;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  byte_index;
        logic [31:0] field_acc;
        logic [27:0] delta_acc;
        kind_t       event_kind;
        logic [7:0]  note_store;
        logic [15:0] division_store;
    } state_t;

    typedef struct packed {
        logic        emit;
        kind_t       kind;
        hdr_err_t    err;
        logic [27:0] delta;
        logic [7:0]  note;
        logic [23:0] tempo;
        logic [15:0] division;
    } result_t;

    // "MThd"
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h4D;
            2'd1:    r = 8'h54;
            2'd2:    r = 8'h68;
            2'd3:    r = 8'h64;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/mfep_decode.sv]
// Byte decoder: next parser state and result for one input byte.
`default_nettype none

module mfep_decode #(
    parameter int MAX_DELTA_BYTES = 4
) (
    input  var mfep_pkg::state_t  cur,
    input  wire logic [7:0]       data_byte,
    output var mfep_pkg::state_t  nxt,
    output var mfep_pkg::result_t res
);

    logic [31:0] acc_shift;
    logic [2:0]  idx_inc;
    logic [27:0] delta_shift;
    logic [7:0]  status_hi;
    logic        magic_ok;

    assign acc_shift   = {cur.field_acc[23:0], data_byte};
    assign idx_inc     = cur.byte_index + 3'd1;
    assign delta_shift = {cur.delta_acc[20:0], data_byte[6:0]};
    assign status_hi   = data_byte & mfep_pkg::STATUS_MASK;
    assign magic_ok    = (data_byte == mfep_pkg::magic_byte(cur.byte_index[1:0]));

    // next state
    always_comb
    begin
        nxt = cur;
        case (cur.phase)
            mfep_pkg::PH_MAGIC:
            begin
                if (!magic_ok)
                begin
                    nxt.phase = mfep_pkg::PH_HALT;
                end
                else if (idx_inc >= 3'd4)
                begin
                    nxt.byte_index = '0;
                    nxt.field_acc  = '0;
                    nxt.phase      = mfep_pkg::PH_LENGTH;
                end
                else
                begin
                    nxt.byte_index = idx_inc;
                end
            end
            mfep_pkg::PH_LENGTH:
            begin
                nxt.field_acc  = acc_shift;
                nxt.byte_index = idx_inc;
                if (idx_inc >= 3'd4)
                begin
                    nxt.byte_index = '0;
                    nxt.field_acc  = '0;
                    nxt.phase      = (acc_shift == mfep_pkg::HEADER_LENGTH)
                                     ? mfep_pkg::PH_FORMAT : mfep_pkg::PH_HALT;
                end
            end
            mfep_pkg::PH_FORMAT:
            begin
                nxt.field_acc  = acc_shift;
                nxt.byte_index = idx_inc;
                if (idx_inc >= 3'd2)
                begin
                    nxt.byte_index = '0;
                    nxt.field_acc  = '0;
                    nxt.phase      = (acc_shift[15:0] == mfep_pkg::HEADER_FORMAT)
                                     ? mfep_pkg::PH_TRACKS : mfep_pkg::PH_HALT;
                end
            end
            mfep_pkg::PH_TRACKS:
            begin
                nxt.field_acc  = acc_shift;
                nxt.byte_index = idx_inc;
                if (idx_inc >= 3'd2)
                begin
                    nxt.byte_index = '0;
                    nxt.field_acc  = '0;
                    nxt.phase      = (acc_shift[15:0] == mfep_pkg::HEADER_TRACKS)
                                     ? mfep_pkg::PH_DIVISION : mfep_pkg::PH_HALT;
                end
            end
            mfep_pkg::PH_DIVISION:
            begin
                nxt.field_acc  = acc_shift;
                nxt.byte_index = idx_inc;
                if (idx_inc >= 3'd2)
                begin
                    nxt.division_store = acc_shift[15:0];
                    nxt.phase          = mfep_pkg::PH_DELTA;
                    nxt.byte_index     = '0;
                    nxt.delta_acc      = '0;
                    nxt.field_acc      = '0;
                    nxt.event_kind     = mfep_pkg::KIND_HDR_OK;
                    nxt.note_store     = '0;
                end
            end
            mfep_pkg::PH_HALT:
            begin
                nxt = cur;
            end
            mfep_pkg::PH_DELTA:
            begin
                nxt.delta_acc  = delta_shift;
                nxt.byte_index = idx_inc;
                if ((data_byte & mfep_pkg::VLQ_CONT) == 8'h00 ||
                    idx_inc >= 3'(MAX_DELTA_BYTES))
                begin
                    nxt.byte_index = '0;
                    nxt.phase      = mfep_pkg::PH_STATUS;
                end
            end
            mfep_pkg::PH_STATUS:
            begin
                if (status_hi == mfep_pkg::STATUS_OFF)
                begin
                    nxt.event_kind = mfep_pkg::KIND_OFF;
                    nxt.phase      = mfep_pkg::PH_NOTE;
                end
                else if (status_hi == mfep_pkg::STATUS_ON)
                begin
                    nxt.event_kind = mfep_pkg::KIND_ON;
                    nxt.phase      = mfep_pkg::PH_NOTE;
                end
                else if (data_byte == mfep_pkg::STATUS_META)
                begin
                    nxt.phase = mfep_pkg::PH_META;
                end
                else
                begin
                    nxt.phase      = mfep_pkg::PH_DELTA;
                    nxt.byte_index = '0;
                    nxt.delta_acc  = '0;
                    nxt.field_acc  = '0;
                    nxt.event_kind = mfep_pkg::KIND_HDR_OK;
                    nxt.note_store = '0;
                end
            end
            mfep_pkg::PH_META:
            begin
                if (data_byte == mfep_pkg::META_EOT)
                begin
                    nxt.phase = mfep_pkg::PH_EOT_LEN;
                end
                else if (data_byte == mfep_pkg::META_TEMPO)
                begin
                    nxt.phase = mfep_pkg::PH_TEMPO_LEN;
                end
                else
                begin
                    nxt.phase      = mfep_pkg::PH_DELTA;
                    nxt.byte_index = '0;
                    nxt.delta_acc  = '0;
                    nxt.field_acc  = '0;
                    nxt.event_kind = mfep_pkg::KIND_HDR_OK;
                    nxt.note_store = '0;
                end
            end
            mfep_pkg::PH_TEMPO_LEN:
            begin
                nxt.field_acc  = '0;
                nxt.byte_index = '0;
                nxt.phase      = mfep_pkg::PH_TEMPO;
            end
            mfep_pkg::PH_TEMPO:
            begin
                nxt.field_acc  = acc_shift;
                nxt.byte_index = idx_inc;
                if (idx_inc >= 3'd3)
                begin
                    nxt.phase      = mfep_pkg::PH_DELTA;
                    nxt.byte_index = '0;
                    nxt.delta_acc  = '0;
                    nxt.field_acc  = '0;
                    nxt.event_kind = mfep_pkg::KIND_HDR_OK;
                    nxt.note_store = '0;
                end
            end
            mfep_pkg::PH_NOTE:
            begin
                nxt.note_store = data_byte;
                nxt.phase      = mfep_pkg::PH_VELOCITY;
            end
            mfep_pkg::PH_EOT_LEN,
            mfep_pkg::PH_VELOCITY:
            begin
                nxt.phase      = mfep_pkg::PH_DELTA;
                nxt.byte_index = '0;
                nxt.delta_acc  = '0;
                nxt.field_acc  = '0;
                nxt.event_kind = mfep_pkg::KIND_HDR_OK;
                nxt.note_store = '0;
            end
            default:
            begin
                nxt.phase = mfep_pkg::PH_HALT;
            end
        endcase
    end

    // result
    always_comb
    begin
        res          = '0;
        res.kind     = mfep_pkg::KIND_HDR_OK;
        res.err      = mfep_pkg::ERR_NONE;
        res.delta    = cur.delta_acc;
        res.division = cur.division_store;
        case (cur.phase)
            mfep_pkg::PH_MAGIC:
            begin
                if (!magic_ok)
                begin
                    res.emit = 1'b1;
                    res.kind = mfep_pkg::KIND_HDR_ERR;
                    res.err  = mfep_pkg::ERR_MAGIC;
                end
            end
            mfep_pkg::PH_LENGTH:
            begin
                if (idx_inc >= 3'd4 && acc_shift != mfep_pkg::HEADER_LENGTH)
                begin
                    res.emit = 1'b1;
                    res.kind = mfep_pkg::KIND_HDR_ERR;
                    res.err  = mfep_pkg::ERR_LENGTH;
                end
            end
            mfep_pkg::PH_FORMAT:
            begin
                if (idx_inc >= 3'd2 && acc_shift[15:0] != mfep_pkg::HEADER_FORMAT)
                begin
                    res.emit = 1'b1;
                    res.kind = mfep_pkg::KIND_HDR_ERR;
                    res.err  = mfep_pkg::ERR_FORMAT;
                end
            end
            mfep_pkg::PH_TRACKS:
            begin
                if (idx_inc >= 3'd2 && acc_shift[15:0] != mfep_pkg::HEADER_TRACKS)
                begin
                    res.emit = 1'b1;
                    res.kind = mfep_pkg::KIND_HDR_ERR;
                    res.err  = mfep_pkg::ERR_TRACKS;
                end
            end
            mfep_pkg::PH_DIVISION:
            begin
                if (idx_inc >= 3'd2)
                begin
                    res.emit     = 1'b1;
                    res.kind     = mfep_pkg::KIND_HDR_OK;
                    res.division = acc_shift[15:0];
                end
            end
            mfep_pkg::PH_STATUS:
            begin
                if (status_hi != mfep_pkg::STATUS_OFF && status_hi != mfep_pkg::STATUS_ON &&
                    data_byte != mfep_pkg::STATUS_META)
                begin
                    res.emit = 1'b1;
                    res.kind = mfep_pkg::KIND_UNKNOWN;
                end
            end
            mfep_pkg::PH_META:
            begin
                if (data_byte != mfep_pkg::META_EOT && data_byte != mfep_pkg::META_TEMPO)
                begin
                    res.emit = 1'b1;
                    res.kind = mfep_pkg::KIND_UNKNOWN;
                end
            end
            mfep_pkg::PH_EOT_LEN:
            begin
                res.emit = 1'b1;
                res.kind = mfep_pkg::KIND_EOT;
            end
            mfep_pkg::PH_TEMPO:
            begin
                if (idx_inc >= 3'd3)
                begin
                    res.emit  = 1'b1;
                    res.kind  = mfep_pkg::KIND_TEMPO;
                    res.tempo = acc_shift[23:0];
                end
            end
            mfep_pkg::PH_VELOCITY:
            begin
                res.emit = 1'b1;
                res.kind = cur.event_kind;
                res.note = cur.note_store;
            end
            default:
            begin
                res.emit = 1'b0;
            end
        endcase
        // header results carry no delta
        if (res.kind == mfep_pkg::KIND_HDR_OK || res.kind == mfep_pkg::KIND_HDR_ERR)
        begin
            res.delta = '0;
        end
    end

endmodule

`default_nettype wire

[hdl/midi_file_event_parser.sv]
// Top level: MIDI file header check and event parser, one byte per beat.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_ready  data_byte
//   out      source     out_valid/out_ready result_kind, header_error, delta_ticks,
//                                          note_number, tempo_value, division_value
//
// One byte is taken per cycle while in_ready is high; the decode is a single pass from the state register.
// A result appears in the output register the cycle after the byte that ends it.
// in_ready drops only while a result is held and out_ready is low.
// rst_n clears parser state and the output valid; header errors halt until reset.
`default_nettype none

module midi_file_event_parser #(
    parameter int MAX_DELTA_BYTES = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output wire logic        in_ready,
    input  wire logic [7:0]  data_byte,
    output wire logic        out_valid,
    input  wire logic        out_ready,
    output wire logic [2:0]  result_kind,
    output wire logic [2:0]  header_error,
    output wire logic [27:0] delta_ticks,
    output wire logic [7:0]  note_number,
    output wire logic [23:0] tempo_value,
    output wire logic [15:0] division_value
);

    mfep_pkg::state_t  state_reg;
    mfep_pkg::state_t  state_next;
    mfep_pkg::result_t res_next;
    mfep_pkg::result_t res_reg;
    logic              out_valid_reg;
    logic              in_beat;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_beat  = in_valid && in_ready;

    mfep_decode #(
        .MAX_DELTA_BYTES(MAX_DELTA_BYTES)
    ) u_decode (
        .cur       (state_reg),
        .data_byte (data_byte),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{phase:          mfep_pkg::PH_MAGIC,
                               byte_index:     '0,
                               field_acc:      '0,
                               delta_acc:      '0,
                               event_kind:     mfep_pkg::KIND_HDR_OK,
                               note_store:     '0,
                               division_store: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                state_reg <= state_next;
            end
            if (in_beat)
            begin
                out_valid_reg <= res_next.emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat && res_next.emit)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = res_reg.kind;
    assign header_error   = res_reg.err;
    assign delta_ticks    = res_reg.delta;
    assign note_number    = res_reg.note;
    assign tempo_value    = res_reg.tempo;
    assign division_value = res_reg.division;

`ifndef SYNTHESIS
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((res_reg.kind == mfep_pkg::KIND_HDR_ERR) ==
                           (res_reg.err != mfep_pkg::ERR_NONE)))
        else $error("header error code does not match result kind");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && state_reg.phase == mfep_pkg::PH_HALT) |=> !out_valid_reg)
        else $error("result emitted after header error");

    a_note_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.kind != mfep_pkg::KIND_ON &&
         res_reg.kind != mfep_pkg::KIND_OFF) |-> (res_reg.note == 8'h00))
        else $error("note number on a non-note result");

    a_hdr_ok_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.kind == mfep_pkg::KIND_HDR_OK) |->
        (state_reg.phase == mfep_pkg::PH_DELTA && state_reg.delta_acc == 28'd0 &&
         state_reg.division_store == res_reg.division))
        else $error("header ok result without event parsing armed");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
// Testbench for midi_file_event_parser: valid header, directed and random events, checked per result.
`timescale 1ns / 100ps

module testbench;

    localparam int DELTA_BYTES  = 4;
    localparam int RANDOM_BYTES = 700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int CALM_FIRST   = 300;
    localparam int CALM_LAST    = 420;
    localparam logic [7:0] SMF_TAG [4] = '{8'h4D, 8'h54, 8'h68, 8'h64};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  result_kind;
    logic [2:0]  header_error;
    logic [27:0] delta_ticks;
    logic [7:0]  note_number;
    logic [23:0] tempo_value;
    logic [15:0] division_value;

    bit          calm = 1'b0;
    int          cycles = 0;
    int          bytes_taken = 0;
    logic [7:0]  file_bytes[$];

    class event_scoreboard;
        mfep_pkg::phase_t  phase = mfep_pkg::PH_MAGIC;
        logic [2:0]        idx = '0;
        logic [31:0]       acc = '0;
        logic [27:0]       delta = '0;
        mfep_pkg::kind_t   ev_kind = mfep_pkg::KIND_HDR_OK;
        logic [7:0]        note = '0;
        logic [15:0]       division = '0;
        bit                header_ok = 1'b0;
        mfep_pkg::result_t expected_events[$];
        int                n_checked = 0;
        int                n_fail = 0;
        int                kind_count[7];

        function void push_result(mfep_pkg::kind_t k, mfep_pkg::hdr_err_t e,
                                  logic [27:0] d, logic [7:0] n, logic [23:0] t);
            mfep_pkg::result_t r;
            r.emit     = 1'b1;
            r.kind     = k;
            r.err      = e;
            r.delta    = d;
            r.note     = n;
            r.tempo    = t;
            r.division = header_ok ? division : 16'h0000;
            expected_events.push_back(r);
        endfunction

        function void restart();
            phase   = mfep_pkg::PH_DELTA;
            idx     = '0;
            delta   = '0;
            acc     = '0;
            ev_kind = mfep_pkg::KIND_HDR_OK;
            note    = '0;
        endfunction

        function bit collect(logic [7:0] b, int nbytes);
            acc = {acc[23:0], b};
            idx = idx + 3'd1;
            if (idx >= nbytes)
            begin
                idx = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void halt(mfep_pkg::hdr_err_t e);
            phase = mfep_pkg::PH_HALT;
            push_result(mfep_pkg::KIND_HDR_ERR, e, '0, '0, '0);
        endfunction

        // one accepted beat on the input side
        function void note_byte(logic [7:0] b);
            logic [27:0]     d;
            logic [7:0]      nt;
            logic [23:0]     t;
            logic [7:0]      hi;
            mfep_pkg::kind_t k;
            hi = b & mfep_pkg::STATUS_MASK;
            case (phase)
                mfep_pkg::PH_MAGIC:
                begin
                    if (b != SMF_TAG[idx[1:0]])
                    begin
                        halt(mfep_pkg::ERR_MAGIC);
                    end
                    else
                    begin
                        idx = idx + 3'd1;
                        if (idx >= 4)
                        begin
                            idx   = '0;
                            acc   = '0;
                            phase = mfep_pkg::PH_LENGTH;
                        end
                    end
                end
                mfep_pkg::PH_LENGTH:
                begin
                    if (collect(b, 4))
                    begin
                        if (acc != mfep_pkg::HEADER_LENGTH)
                        begin
                            halt(mfep_pkg::ERR_LENGTH);
                        end
                        else
                        begin
                            acc   = '0;
                            phase = mfep_pkg::PH_FORMAT;
                        end
                    end
                end
                mfep_pkg::PH_FORMAT:
                begin
                    if (collect(b, 2))
                    begin
                        if (acc[15:0] != mfep_pkg::HEADER_FORMAT)
                        begin
                            halt(mfep_pkg::ERR_FORMAT);
                        end
                        else
                        begin
                            acc   = '0;
                            phase = mfep_pkg::PH_TRACKS;
                        end
                    end
                end
                mfep_pkg::PH_TRACKS:
                begin
                    if (collect(b, 2))
                    begin
                        if (acc[15:0] != mfep_pkg::HEADER_TRACKS)
                        begin
                            halt(mfep_pkg::ERR_TRACKS);
                        end
                        else
                        begin
                            acc   = '0;
                            phase = mfep_pkg::PH_DIVISION;
                        end
                    end
                end
                mfep_pkg::PH_DIVISION:
                begin
                    if (collect(b, 2))
                    begin
                        division  = acc[15:0];
                        header_ok = 1'b1;
                        restart();
                        push_result(mfep_pkg::KIND_HDR_OK, mfep_pkg::ERR_NONE, '0, '0, '0);
                    end
                end
                mfep_pkg::PH_DELTA:
                begin
                    delta = {delta[20:0], b[6:0]};
                    idx   = idx + 3'd1;
                    if ((b & mfep_pkg::VLQ_CONT) == 8'h00 || idx >= DELTA_BYTES)
                    begin
                        idx   = '0;
                        phase = mfep_pkg::PH_STATUS;
                    end
                end
                mfep_pkg::PH_STATUS:
                begin
                    if (hi == mfep_pkg::STATUS_OFF || hi == mfep_pkg::STATUS_ON)
                    begin
                        ev_kind = (hi == mfep_pkg::STATUS_OFF) ? mfep_pkg::KIND_OFF
                                                               : mfep_pkg::KIND_ON;
                        phase   = mfep_pkg::PH_NOTE;
                    end
                    else if (b == mfep_pkg::STATUS_META)
                    begin
                        phase = mfep_pkg::PH_META;
                    end
                    else
                    begin
                        d = delta;
                        restart();
                        push_result(mfep_pkg::KIND_UNKNOWN, mfep_pkg::ERR_NONE, d, '0, '0);
                    end
                end
                mfep_pkg::PH_META:
                begin
                    if (b == mfep_pkg::META_EOT)
                    begin
                        phase = mfep_pkg::PH_EOT_LEN;
                    end
                    else if (b == mfep_pkg::META_TEMPO)
                    begin
                        phase = mfep_pkg::PH_TEMPO_LEN;
                    end
                    else
                    begin
                        d = delta;
                        restart();
                        push_result(mfep_pkg::KIND_UNKNOWN, mfep_pkg::ERR_NONE, d, '0, '0);
                    end
                end
                mfep_pkg::PH_EOT_LEN:
                begin
                    d = delta;
                    restart();
                    push_result(mfep_pkg::KIND_EOT, mfep_pkg::ERR_NONE, d, '0, '0);
                end
                mfep_pkg::PH_TEMPO_LEN:
                begin
                    acc   = '0;
                    idx   = '0;
                    phase = mfep_pkg::PH_TEMPO;
                end
                mfep_pkg::PH_TEMPO:
                begin
                    if (collect(b, 3))
                    begin
                        t = acc[23:0];
                        d = delta;
                        restart();
                        push_result(mfep_pkg::KIND_TEMPO, mfep_pkg::ERR_NONE, d, '0, t);
                    end
                end
                mfep_pkg::PH_NOTE:
                begin
                    note  = b;
                    phase = mfep_pkg::PH_VELOCITY;
                end
                mfep_pkg::PH_VELOCITY:
                begin
                    k  = ev_kind;
                    nt = note;
                    d  = delta;
                    restart();
                    push_result(k, mfep_pkg::ERR_NONE, d, nt, '0);
                end
                default:
                begin
                    phase = mfep_pkg::PH_HALT;
                end
            endcase
        endfunction

        function void compare(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
                n_fail++;
            end
        endfunction

        function void check_event(logic [2:0] k, logic [2:0] e, logic [27:0] d,
                                  logic [7:0] n, logic [23:0] t, logic [15:0] dv);
            mfep_pkg::result_t want;
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got kind %0d", $time, k);
                n_fail++;
                return;
            end
            want = expected_events.pop_front();
            n_checked++;
            kind_count[want.kind]++;
            compare("result_kind", want.kind, k);
            compare("header_error", want.err, e);
            compare("delta_ticks", want.delta, d);
            compare("note_number", want.note, n);
            compare("tempo_value", want.tempo, t);
            compare("division_value", want.division, dv);
        endfunction
    endclass

    event_scoreboard sb = new;

    midi_file_event_parser #(
        .MAX_DELTA_BYTES (DELTA_BYTES)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .header_error   (header_error),
        .delta_ticks    (delta_ticks),
        .note_number    (note_number),
        .tempo_value    (tempo_value),
        .division_value (division_value)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out after %0d cycles", $time, cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_event(result_kind, header_error, delta_ticks, note_number,
                               tempo_value, division_value);
            if (in_valid && in_ready)
            begin
                sb.note_byte(data_byte);
                bytes_taken++;
            end
        end
    end

    // well-formed event with random content, or a short burst of noise
    function automatic void add_random_event();
        int         pick;
        int         nd;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
            return;
        end
        nd = $urandom_range(1, DELTA_BYTES);
        for (int i = 0; i < nd; i++)
        begin
            b = 8'($urandom_range(127));
            // a full-length delta may keep its continuation bit on the last byte
            if (i < nd - 1 || (nd == DELTA_BYTES && $urandom_range(3) == 0))
                b = b | mfep_pkg::VLQ_CONT;
            file_bytes.push_back(b);
        end
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            b = ($urandom_range(1) != 0) ? mfep_pkg::STATUS_ON : mfep_pkg::STATUS_OFF;
            file_bytes.push_back(b | 8'($urandom_range(15)));
            file_bytes.push_back(8'($urandom));
            file_bytes.push_back(8'($urandom));
        end
        else if (pick < 45)
        begin
            file_bytes.push_back(mfep_pkg::STATUS_META);
            file_bytes.push_back(mfep_pkg::META_EOT);
            file_bytes.push_back(8'($urandom));
        end
        else if (pick < 65)
        begin
            file_bytes.push_back(mfep_pkg::STATUS_META);
            file_bytes.push_back(mfep_pkg::META_TEMPO);
            repeat (4) file_bytes.push_back(8'($urandom));
        end
        else if (pick < 80)
        begin
            do b = 8'($urandom);
            while (b == mfep_pkg::META_EOT || b == mfep_pkg::META_TEMPO);
            file_bytes.push_back(mfep_pkg::STATUS_META);
            file_bytes.push_back(b);
        end
        else
        begin
            do b = 8'($urandom);
            while ((b & mfep_pkg::STATUS_MASK) == mfep_pkg::STATUS_OFF ||
                   (b & mfep_pkg::STATUS_MASK) == mfep_pkg::STATUS_ON ||
                   b == mfep_pkg::STATUS_META);
            file_bytes.push_back(b);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    // output side: random stalls, one long hold-off to back the parser up
    initial
    begin : receiver
        int hold;
        bit held;
        hold = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && sb.n_checked >= 60)
            begin
                hold = 150;
                held = 1'b1;
            end
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= 22);
            end
        end
    end

    initial
    begin : stimulus
        logic [15:0] division;
        int          target;
        division = 16'($urandom_range(65535));
        foreach (SMF_TAG[i]) file_bytes.push_back(SMF_TAG[i]);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(mfep_pkg::HEADER_LENGTH[8*i +: 8]);
        file_bytes.push_back(mfep_pkg::HEADER_FORMAT[15:8]);
        file_bytes.push_back(mfep_pkg::HEADER_FORMAT[7:0]);
        file_bytes.push_back(mfep_pkg::HEADER_TRACKS[15:8]);
        file_bytes.push_back(mfep_pkg::HEADER_TRACKS[7:0]);
        file_bytes.push_back(division[15:8]);
        file_bytes.push_back(division[7:0]);

        file_bytes.push_back(8'h00);
        file_bytes.push_back(mfep_pkg::STATUS_ON);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h7F);
        file_bytes.push_back(8'h7F);
        file_bytes.push_back(mfep_pkg::STATUS_OFF | 8'h0F);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h00);
        // largest delta, largest tempo
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h7F);
        file_bytes.push_back(mfep_pkg::STATUS_META);
        file_bytes.push_back(mfep_pkg::META_TEMPO);
        file_bytes.push_back(8'h03);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hFF);
        // continuation bit on the fourth delta byte is ignored
        file_bytes.push_back(8'h81);
        file_bytes.push_back(8'h80);
        file_bytes.push_back(8'h80);
        file_bytes.push_back(8'h80);
        file_bytes.push_back(mfep_pkg::STATUS_META);
        file_bytes.push_back(mfep_pkg::META_EOT);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hA5);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(mfep_pkg::STATUS_META);
        file_bytes.push_back(8'h01);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(mfep_pkg::STATUS_META);
        file_bytes.push_back(mfep_pkg::META_TEMPO);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);

        target = file_bytes.size() + RANDOM_BYTES;
        while (file_bytes.size() < target) add_random_event();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (file_bytes[i])
        begin
            calm = (i >= CALM_FIRST && i < CALM_LAST);
            send_byte(file_bytes[i]);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        @(posedge clk);
        while (sb.expected_events.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent a valid header (division 0x%0h) and %0d file bytes; %0d results checked.",
                 division, bytes_taken, sb.n_checked);
        $display("Note off %0d, note on %0d, end of track %0d, tempo %0d, unknown %0d.",
                 sb.kind_count[mfep_pkg::KIND_OFF], sb.kind_count[mfep_pkg::KIND_ON],
                 sb.kind_count[mfep_pkg::KIND_EOT], sb.kind_count[mfep_pkg::KIND_TEMPO],
                 sb.kind_count[mfep_pkg::KIND_UNKNOWN]);
        if (sb.n_fail == 0 && sb.expected_events.size() == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
